// ===== rtl/core/ile_pkg.sv =====
// Shared types, codes and stream layout for the indexed list engine.
`timescale 1ns / 1ps

package ile_pkg;

  // Default store geometry
  localparam int unsigned CAPACITY_DEF     = 1024;
  localparam int unsigned ELEMENT_BITS_DEF = 32;

  // Field widths on the streams
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned LENGTH_W = 11;

  // Input word: position, value, zero fill
  localparam int unsigned IN_POS_LSB   = 0;
  localparam int unsigned IN_VALUE_LSB = IN_POS_LSB + POS_W;
  localparam int unsigned IN_USED_W    = IN_VALUE_LSB + VALUE_W;
  localparam int unsigned IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output word: value_out, index_out, length, is_empty, zero fill
  localparam int unsigned OUT_VALUE_LSB  = 0;
  localparam int unsigned OUT_INDEX_LSB  = OUT_VALUE_LSB + VALUE_W;
  localparam int unsigned OUT_LENGTH_LSB = OUT_INDEX_LSB + INDEX_W;
  localparam int unsigned OUT_EMPTY_BIT  = OUT_LENGTH_LSB + LENGTH_W;
  localparam int unsigned OUT_USED_W     = OUT_EMPTY_BIT + 1;
  localparam int unsigned OUT_DATA_W     = ((OUT_USED_W + 7) / 8) * 8;

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_READ      = 3'd1,
    OP_OVERWRITE = 3'd2,
    OP_INSERT    = 3'd3,
    OP_REMOVE    = 3'd4,
    OP_FIND      = 3'd5,
    OP_CLEAR     = 3'd6
  } op_e;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

endpackage

// ===== rtl/core/ile_ram.sv =====
// Element store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ile_ram #(
  parameter int unsigned DEPTH = ile_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = ile_pkg::ELEMENT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/indexed_list_engine.sv =====
// Indexed list engine: ordered list of element handles with shifting insert and remove.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser: kind; tdata: position, value
//  m_axis    out        m_axis_tvalid / m_axis_tready  tuser: status; tdata: value_out,
//                                                      index_out, length, is_empty
//
//  One word is taken at a time; s_axis_tready is high only while the sequencer idles.
//  Append, overwrite, clear and rejected operations go straight to the response step;
//  read, insert and remove walk the store and find scans it from the head, where one
//  store entry is stepped per cycle through the single read port.
//  Reset clears the count, the handshake state and the other registers; the store is
//  not swept. A result waits in the output register while m_axis_tready is low; the
//  engine may take the next word but then holds in its response step until the
//  register is free.

module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int unsigned CAPACITY     = CAPACITY_DEF,
  parameter int unsigned ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Operation stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [10:0] position, [42:11] value, rest zero
  input  logic [KIND_W-1:0]     s_axis_tuser,   // [2:0] kind
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] value_out, [41:32] index_out,
                                                // [52:42] length, [53] is_empty, rest zero
  output logic [STATUS_W-1:0]   m_axis_tuser    // [2:0] status
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned EW   = ELEMENT_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_FLUSH,
    S_PUT,
    S_FIND,
    S_RESP
  } state_e;

  state_e               state_q, state_d;
  op_e                  kind_q, kind_d;
  logic [CW-1:0]        pos_q, pos_d;
  logic [EW-1:0]        val_q, val_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        rp_q, rp_d;       // read pointer of the walk
  logic [CW-1:0]        end_q, end_d;     // last index the walk reads
  logic [CW-1:0]        wa_q, wa_d;       // index the pending read data is written to (shift) or belongs to (find)
  logic                 pend_q, pend_d;   // read data in flight must be written or compared
  logic                 cap_q, cap_d;     // read data in flight is the returned element
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic [EW-1:0]        res_vout_q, res_vout_d;
  logic [CW-1:0]        res_iout_q, res_iout_d;
  logic                 m_valid_q, m_valid_d;
  logic [STATUS_W-1:0]  m_status_q, m_status_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  // Store ports
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [EW-1:0]        wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [EW-1:0]        rd_data;

  // Unpacked input fields
  op_e                  in_kind;
  logic [POS_W-1:0]     in_pos;
  logic [EW-1:0]        in_val;
  logic                 in_null;
  logic [CMPW-1:0]      pos_ext;
  logic [CMPW-1:0]      cnt_ext;
  logic                 full;
  logic                 is_ins;

  assign in_kind = op_e'(s_axis_tuser);
  assign in_pos  = s_axis_tdata[IN_POS_LSB +: POS_W];
  assign in_val  = EW'(s_axis_tdata[IN_VALUE_LSB +: VALUE_W]);
  assign in_null = (in_val == '0);
  assign pos_ext = CMPW'(in_pos);
  assign cnt_ext = CMPW'(count_q);
  assign full    = (count_q == CW'(CAPACITY));
  assign is_ins  = (kind_q == OP_INSERT);

  assign s_axis_tready = (state_q == S_IDLE);

  ile_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    pos_d        = pos_q;
    val_d        = val_q;
    count_d      = count_q;
    rp_d         = rp_q;
    end_d        = end_q;
    wa_d         = wa_q;
    pend_d       = pend_q;
    cap_d        = cap_q;
    res_status_d = res_status_q;
    res_vout_d   = res_vout_q;
    res_iout_d   = res_iout_q;
    m_valid_d    = m_valid_q;
    m_status_d   = m_status_q;
    m_data_d     = m_data_q;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = in_val;
    rd_en        = 1'b0;
    rd_addr      = rp_q[AW-1:0];

    // Drop the output word once taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d       = in_kind;
          pos_d        = CW'(in_pos);
          val_d        = in_val;
          pend_d       = 1'b0;
          cap_d        = 1'b0;
          res_status_d = ST_OK;
          res_vout_d   = '0;
          res_iout_d   = '0;
          state_d      = S_RESP;
          case (in_kind)
            OP_APPEND: begin
              if (in_null) begin
                res_status_d = ST_NULL;
              end else if (full) begin
                res_status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = count_q[AW-1:0];
                count_d = count_q + CW'(1);
              end
            end
            OP_READ: begin
              if (pos_ext >= cnt_ext) begin
                res_status_d = ST_BAD_INDEX;
              end else begin
                rp_d    = CW'(in_pos);
                end_d   = CW'(in_pos);
                state_d = S_SHIFT;
              end
            end
            OP_OVERWRITE: begin
              if (in_null) begin
                res_status_d = ST_NULL;
              end else if (pos_ext > cnt_ext) begin
                res_status_d = ST_BAD_INDEX;
              end else if (pos_ext < cnt_ext) begin
                wr_en   = 1'b1;
                wr_addr = AW'(in_pos);
              end else if (full) begin
                res_status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = count_q[AW-1:0];
                count_d = count_q + CW'(1);
              end
            end
            OP_INSERT: begin
              if (in_null) begin
                res_status_d = ST_NULL;
              end else if (pos_ext > cnt_ext) begin
                res_status_d = ST_BAD_INDEX;
              end else if (full) begin
                res_status_d = ST_FULL;
              end else if (pos_ext == cnt_ext) begin
                // Insert at the end: nothing to shift
                wr_en   = 1'b1;
                wr_addr = count_q[AW-1:0];
                count_d = count_q + CW'(1);
              end else begin
                rp_d    = count_q - CW'(1);
                end_d   = CW'(in_pos);
                state_d = S_SHIFT;
              end
            end
            OP_REMOVE: begin
              if (pos_ext >= cnt_ext) begin
                res_status_d = ST_BAD_INDEX;
              end else begin
                rp_d    = CW'(in_pos);
                end_d   = count_q - CW'(1);
                state_d = S_SHIFT;
              end
            end
            OP_FIND: begin
              if (in_null) begin
                res_status_d = ST_NULL;
              end else if (count_q == '0) begin
                res_status_d = ST_NOT_FOUND;
              end else begin
                rp_d    = '0;
                end_d   = count_q - CW'(1);
                state_d = S_FIND;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Walk the store: read one entry, write the previous one a step over when shifting
      S_SHIFT: begin
        rd_en = 1'b1;
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = wa_q[AW-1:0];
          wr_data = rd_data;
        end
        if (cap_q) begin
          res_vout_d = rd_data;
        end
        pend_d = is_ins || ((kind_q == OP_REMOVE) && (rp_q != pos_q));
        cap_d  = !is_ins && (rp_q == pos_q);
        wa_d   = is_ins ? rp_q + CW'(1) : rp_q - CW'(1);
        if (rp_q == end_q) begin
          state_d = S_FLUSH;
        end else begin
          rp_d = is_ins ? rp_q - CW'(1) : rp_q + CW'(1);
        end
      end

      // Retire the last read of the walk
      S_FLUSH: begin
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = wa_q[AW-1:0];
          wr_data = rd_data;
        end
        if (cap_q) begin
          res_vout_d = rd_data;
        end
        pend_d = 1'b0;
        cap_d  = 1'b0;
        if (is_ins) begin
          state_d = S_PUT;
        end else begin
          if (kind_q == OP_REMOVE) begin
            count_d = count_q - CW'(1);
          end
          state_d = S_RESP;
        end
      end

      // Place the inserted element in the opened slot
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_q[AW-1:0];
        wr_data = val_q;
        count_d = count_q + CW'(1);
        state_d = S_RESP;
      end

      // Scan from the head; compare each entry the cycle after its read
      S_FIND: begin
        rd_en  = (rp_q <= end_q);
        pend_d = 1'b1;
        wa_d   = rp_q;
        rp_d   = rp_q + CW'(1);
        if (pend_q) begin
          if (rd_data == val_q) begin
            res_status_d = ST_OK;
            res_iout_d   = wa_q;
            pend_d       = 1'b0;
            state_d      = S_RESP;
          end else if (wa_q == end_q) begin
            res_status_d = ST_NOT_FOUND;
            pend_d       = 1'b0;
            state_d      = S_RESP;
          end
        end
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_data_d   = '0;
          m_data_d[OUT_VALUE_LSB +: VALUE_W]   = VALUE_W'(res_vout_q);
          m_data_d[OUT_INDEX_LSB +: INDEX_W]   = INDEX_W'(res_iout_q);
          m_data_d[OUT_LENGTH_LSB +: LENGTH_W] = LENGTH_W'(count_q);
          m_data_d[OUT_EMPTY_BIT]              = (count_q == '0);
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      pend_q       <= 1'b0;
      cap_q        <= 1'b0;
      m_valid_q    <= 1'b0;
      kind_q       <= OP_APPEND;
      pos_q        <= '0;
      val_q        <= '0;
      rp_q         <= '0;
      end_q        <= '0;
      wa_q         <= '0;
      res_status_q <= ST_OK;
      res_vout_q   <= '0;
      res_iout_q   <= '0;
      m_status_q   <= ST_OK;
      m_data_q     <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      pend_q       <= pend_d;
      cap_q        <= cap_d;
      m_valid_q    <= m_valid_d;
      kind_q       <= kind_d;
      pos_q        <= pos_d;
      val_q        <= val_d;
      rp_q         <= rp_d;
      end_q        <= end_d;
      wa_q         <= wa_d;
      res_status_q <= res_status_d;
      res_vout_q   <= res_vout_d;
      res_iout_q   <= res_iout_d;
      m_status_q   <= m_status_d;
      m_data_q     <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;

endmodule

// ===== rtl/core/ile_checker.sv =====
// Port-level checker for the indexed list engine, bound to the top level.
`timescale 1ns / 1ps

module ile_checker
  import ile_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [KIND_W-1:0]     s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0]   m_axis_tuser
);

  // One word at a time: the engine goes busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while the engine was still busy");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed or vanished while stalled");

  // Empty flag agrees with the reported length
  a_empty_matches_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[OUT_EMPTY_BIT] == (m_axis_tdata[OUT_LENGTH_LSB +: LENGTH_W] == '0)))
    else $error("is_empty disagrees with length");

  // A failed operation returns no element and no index
  a_fail_clears_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |->
      ((m_axis_tdata[OUT_VALUE_LSB +: VALUE_W] == '0) &&
       (m_axis_tdata[OUT_INDEX_LSB +: INDEX_W] == '0)))
    else $error("failed operation carries a value or index");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (.*);
